>>> src/avqm_pkg.sv
// Shared types, constants and helpers of the adaptive virtual queue marker.
package avqm_pkg;

  localparam int TIME_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int CHUNK_W   = TIME_BITS / 2;
  localparam int CAP_W     = 33;
  localparam int PROD_W    = CAP_W + CHUNK_W;
  localparam int ACC_W     = CAP_W + TIME_BITS;
  localparam int VLEN_W    = 48;
  localparam int RLEN_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int TMP_W     = 31;
  localparam int DEC_W     = 30;

  localparam int unsigned ALPHA_Q = ((15 << FRAC_BITS) + 50) / 100;
  localparam logic [VLEN_W-1:0] VLEN_MAX = '1;
  localparam logic [RLEN_W-1:0] RLEN_MAX = '1;

  localparam logic [1:0] PH_HI = 2'd0;
  localparam logic [1:0] PH_LO = 2'd1;
  localparam logic [1:0] PH_WB = 2'd2;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DEPART = 1'b1;

  typedef enum logic [2:0] {
    REG_LINK_RATE  = 3'd0,
    REG_ECN_FRAC   = 3'd1,
    REG_BUF_FRAC   = 3'd2,
    REG_TARGET     = 3'd3,
    REG_MEAN_PKT   = 3'd4,
    REG_QUEUE_LIM  = 3'd5,
    REG_POLICY     = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM,
    ST_CAP0,
    ST_DRAIN,
    ST_ADDU,
    ST_VBUF,
    ST_AG,
    ST_INC,
    ST_DEC,
    ST_GROW,
    ST_CAP,
    ST_REAL,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic              cmd;
    logic [TIME_BITS-1:0] now;
    logic [SIZE_W-1:0] pkt_size;
    logic              ect;
  } in_word_t;

  typedef struct packed {
    logic              mark_this;
    logic              mark_head;
    logic              drop_this;
    logic [1:0]        head_drops;
    logic [RLEN_W-1:0] queue_len;
  } out_word_t;

  // Subtract, floored at zero.
  function automatic logic [RLEN_W-1:0] sub_floor_len(logic [RLEN_W-1:0] a,
                                                      logic [SIZE_W-1:0] b);
    logic [RLEN_W-1:0] bx;
    bx = RLEN_W'(b);
    return (a > bx) ? (a - bx) : '0;
  endfunction

endpackage

>>> src/adaptive_virtual_queue_marker.sv
// Top level of the adaptive virtual queue marker: sequencer, shared MAC, state.
// Arrival: the first arrival also sets the initial virtual capacity, and a virtual drop in
//   drop mode skips adaptation; no new word is taken until the result is in the output register.
// Departure: goes straight to ST_DONE, which loads the output register once it is free.
// The arithmetic runs on one shared 33x16 multiply-accumulate, one product at a time.
// Synchronous reset clears the queue state and loads the register defaults.
module adaptive_virtual_queue_marker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  avqm_pkg::in_word_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output avqm_pkg::out_word_t    out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [avqm_pkg::ADDR_W-1:0] paddr,
  input  logic [avqm_pkg::DATA_W-1:0] pwdata,
  output logic [avqm_pkg::DATA_W-1:0] prdata,
  output logic                   pready
);
  import avqm_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers, written over the APB port only while the block is idle: a user rule, not enforced
  // ---------------------------------------------------------------------------
  logic [31:0] link_rate_r;
  logic [16:0] ecn_frac_r;
  logic [17:0] buf_frac_r;
  logic [16:0] target_r;
  logic [15:0] mean_pkt_r;
  logic [15:0] queue_lim_r;
  logic [3:0]  policy_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_rate_r <= 32'd65536;
      ecn_frac_r  <= 17'd52429;
      buf_frac_r  <= 18'd65536;
      target_r    <= 17'd64225;
      mean_pkt_r  <= 16'd1000;
      queue_lim_r <= 16'd50;
      policy_r    <= 4'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LINK_RATE: link_rate_r <= pwdata;
        REG_ECN_FRAC:  ecn_frac_r  <= pwdata[16:0];
        REG_BUF_FRAC:  buf_frac_r  <= pwdata[17:0];
        REG_TARGET:    target_r    <= pwdata[16:0];
        REG_MEAN_PKT:  mean_pkt_r  <= pwdata[15:0];
        REG_QUEUE_LIM: queue_lim_r <= pwdata[15:0];
        REG_POLICY:    policy_r    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back: registers are zero-extended to the bus width
  always_comb begin
    unique case (cfg_idx)
      REG_LINK_RATE: prdata = link_rate_r;
      REG_ECN_FRAC:  prdata = DATA_W'(ecn_frac_r);
      REG_BUF_FRAC:  prdata = DATA_W'(buf_frac_r);
      REG_TARGET:    prdata = DATA_W'(target_r);
      REG_MEAN_PKT:  prdata = DATA_W'(mean_pkt_r);
      REG_QUEUE_LIM: prdata = DATA_W'(queue_lim_r);
      REG_POLICY:    prdata = DATA_W'(policy_r);
      default:       prdata = '0;
    endcase
  end

  // Policy bits
  logic bytes_mode, mark_mode, mark_front, drop_front;
  assign bytes_mode = policy_r[0];
  assign mark_mode  = policy_r[1];
  assign mark_front = policy_r[2];
  assign drop_front = policy_r[3];

  // ---------------------------------------------------------------------------
  // Sequencer and datapath state
  // ---------------------------------------------------------------------------
  st_t                  state_r, state_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;

  logic [RLEN_W-1:0]    real_len_r, real_len_nxt;
  logic [VLEN_W-1:0]    virt_len_r, virt_len_nxt;
  logic [CAP_W-1:0]     virt_cap_r, virt_cap_nxt;
  logic [TIME_BITS-1:0] adapt_time_r, adapt_time_nxt;
  logic [TIME_BITS-1:0] drain_time_r, drain_time_nxt;
  logic                 first_r, first_nxt;

  // Per-word working registers (payload, no reset)
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 ect_r, ect_nxt;
  logic [SIZE_W-1:0]    u_r, u_nxt;
  logic [RLEN_W-1:0]    lim_r, lim_nxt;
  logic [TMP_W-1:0]     tmp_r, tmp_nxt;
  logic [DEC_W-1:0]     dec_r, dec_nxt;
  logic                 m_this_r, m_this_nxt;
  logic                 m_head_r, m_head_nxt;
  logic                 d_this_r, d_this_nxt;
  logic [1:0]           hdrops_r, hdrops_nxt;

  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_data_r, out_data_nxt;

  logic                 in_acc;
  logic [SIZE_W-1:0]    u_in;

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign u_in      = bytes_mode ? in_data.pkt_size : SIZE_W'(1);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Shared multiply-accumulate: A (up to 33 bits) times B (32 bits), taken as
  // two 16-bit digits, high digit first; the product lands in acc_r.
  // ---------------------------------------------------------------------------
  logic                 is_mul;
  logic [CAP_W-1:0]     a_op;
  logic [TIME_BITS-1:0] b_op;
  logic [CHUNK_W-1:0]   b_dig;
  logic [PROD_W-1:0]    prod;

  always_comb begin
    is_mul = 1'b1;
    a_op   = '0;
    b_op   = '0;
    case (state_r)
      ST_LIM: begin
        a_op = CAP_W'(queue_lim_r);
        b_op = bytes_mode ? TIME_BITS'(mean_pkt_r) : TIME_BITS'(1);
      end
      ST_CAP0: begin
        a_op = CAP_W'(ecn_frac_r);
        b_op = link_rate_r;
      end
      ST_DRAIN: begin
        a_op = virt_cap_r;
        b_op = now_r - drain_time_r;
      end
      ST_VBUF: begin
        a_op = CAP_W'(buf_frac_r);
        b_op = lim_r;
      end
      ST_AG: begin
        a_op = CAP_W'(target_r);
        b_op = TIME_BITS'(ALPHA_Q);
      end
      ST_INC: begin
        a_op = CAP_W'(tmp_r);
        b_op = link_rate_r;
      end
      ST_DEC: begin
        a_op = CAP_W'(u_r);
        b_op = TIME_BITS'(ALPHA_Q);
      end
      ST_GROW: begin
        a_op = CAP_W'(tmp_r);
        b_op = now_r - adapt_time_r;
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign b_dig = (phase_r == PH_HI) ? b_op[TIME_BITS-1:CHUNK_W] : b_op[CHUNK_W-1:0];
  assign prod  = PROD_W'(a_op) * PROD_W'(b_dig);

  // ---------------------------------------------------------------------------
  // Next state and datapath updates
  // ---------------------------------------------------------------------------
  logic [VLEN_W:0]      vsum;
  logic [VLEN_W-1:0]    uq;
  logic [ACC_W-1:0]     cap_t;

  assign uq    = VLEN_W'({u_r, {FRAC_BITS{1'b0}}});
  assign vsum  = {1'b0, virt_len_r} + {1'b0, uq};
  assign cap_t = (acc_r > ACC_W'(dec_r)) ? (acc_r - ACC_W'(dec_r)) : '0;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    real_len_nxt   = real_len_r;
    virt_len_nxt   = virt_len_r;
    virt_cap_nxt   = virt_cap_r;
    adapt_time_nxt = adapt_time_r;
    drain_time_nxt = drain_time_r;
    first_nxt      = first_r;
    now_nxt        = now_r;
    ect_nxt        = ect_r;
    u_nxt          = u_r;
    lim_nxt        = lim_r;
    tmp_nxt        = tmp_r;
    dec_nxt        = dec_r;
    m_this_nxt     = m_this_r;
    m_head_nxt     = m_head_r;
    d_this_nxt     = d_this_r;
    hdrops_nxt     = hdrops_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    // Digit steps of any product; the write-back phase is handled per state
    if (is_mul && (phase_r != PH_WB)) begin
      if (phase_r == PH_HI) begin
        acc_nxt = ACC_W'(prod);
      end else begin
        acc_nxt = (acc_r << CHUNK_W) + ACC_W'(prod);
      end
      phase_nxt = phase_r + 2'd1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          now_nxt    = in_data.now;
          ect_nxt    = in_data.ect;
          u_nxt      = u_in;
          m_this_nxt = 1'b0;
          m_head_nxt = 1'b0;
          d_this_nxt = 1'b0;
          hdrops_nxt = 2'd0;
          phase_nxt  = PH_HI;
          if (in_data.cmd == CMD_DEPART) begin
            real_len_nxt = sub_floor_len(real_len_r, u_in);
            state_nxt    = ST_DONE;
          end else begin
            if ((real_len_r + RLEN_W'(u_in)) < real_len_r) begin
              real_len_nxt = RLEN_MAX;
            end else begin
              real_len_nxt = real_len_r + RLEN_W'(u_in);
            end
            state_nxt = ST_LIM;
          end
        end
      end
      ST_LIM: begin
        if (phase_r == PH_WB) begin
          lim_nxt   = acc_r[RLEN_W-1:0];
          phase_nxt = PH_HI;
          state_nxt = first_r ? ST_CAP0 : ST_DRAIN;
        end
      end
      ST_CAP0: begin
        if (phase_r == PH_WB) begin
          virt_cap_nxt   = acc_r[FRAC_BITS +: CAP_W];
          adapt_time_nxt = now_r;
          drain_time_nxt = now_r;
          first_nxt      = 1'b0;
          phase_nxt      = PH_HI;
          state_nxt      = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (phase_r == PH_WB) begin
          // Drain, floored at zero
          if (ACC_W'(virt_len_r) > acc_r) begin
            virt_len_nxt = virt_len_r - acc_r[VLEN_W-1:0];
          end else begin
            virt_len_nxt = '0;
          end
          drain_time_nxt = now_r;
          state_nxt      = ST_ADDU;
        end
      end
      ST_ADDU: begin
        virt_len_nxt = vsum[VLEN_W] ? VLEN_MAX : vsum[VLEN_W-1:0];
        phase_nxt    = PH_HI;
        state_nxt    = ST_VBUF;
      end
      ST_VBUF: begin
        if (phase_r == PH_WB) begin
          phase_nxt = PH_HI;
          state_nxt = ST_AG;
          if (ACC_W'(virt_len_r) > acc_r) begin
            virt_len_nxt = (virt_len_r > uq) ? (virt_len_r - uq) : '0;
            if (mark_mode) begin
              if (mark_front) begin
                m_head_nxt = 1'b1;
              end else begin
                m_this_nxt = ect_r;
              end
            end else begin
              if (drop_front) begin
                hdrops_nxt = hdrops_r + 2'd1;
              end else begin
                d_this_nxt = 1'b1;
              end
              real_len_nxt = sub_floor_len(real_len_r, u_r);
              state_nxt    = ST_REAL;
            end
          end
        end
      end
      ST_AG: begin
        if (phase_r == PH_WB) begin
          tmp_nxt   = acc_r[FRAC_BITS +: TMP_W];
          phase_nxt = PH_HI;
          state_nxt = ST_INC;
        end
      end
      ST_INC: begin
        if (phase_r == PH_WB) begin
          tmp_nxt   = acc_r[FRAC_BITS +: TMP_W];
          phase_nxt = PH_HI;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (phase_r == PH_WB) begin
          dec_nxt   = acc_r[DEC_W-1:0];
          phase_nxt = PH_HI;
          state_nxt = ST_GROW;
        end
      end
      ST_GROW: begin
        if (phase_r == PH_WB) begin
          acc_nxt   = acc_r + ACC_W'(virt_cap_r);
          state_nxt = ST_CAP;
        end
      end
      ST_CAP: begin
        // Clamp to the link rate
        if (cap_t > ACC_W'(link_rate_r)) begin
          virt_cap_nxt = CAP_W'(link_rate_r);
        end else begin
          virt_cap_nxt = cap_t[CAP_W-1:0];
        end
        adapt_time_nxt = now_r;
        state_nxt      = ST_REAL;
      end
      ST_REAL: begin
        if (real_len_r > lim_r) begin
          if (drop_front) begin
            hdrops_nxt   = hdrops_r + 2'd1;
            real_len_nxt = sub_floor_len(real_len_r, u_r);
          end else if (!d_this_r) begin
            d_this_nxt   = 1'b1;
            real_len_nxt = sub_floor_len(real_len_r, u_r);
          end
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.mark_this  = m_this_r;
          out_data_nxt.mark_head  = m_head_r;
          out_data_nxt.drop_this  = d_this_r;
          out_data_nxt.head_drops = hdrops_r;
          out_data_nxt.queue_len  = real_len_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and queue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_HI;
      out_valid_r  <= 1'b0;
      real_len_r   <= '0;
      virt_len_r   <= '0;
      virt_cap_r   <= '0;
      adapt_time_r <= '0;
      drain_time_r <= '0;
      first_r      <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
      real_len_r   <= real_len_nxt;
      virt_len_r   <= virt_len_nxt;
      virt_cap_r   <= virt_cap_nxt;
      adapt_time_r <= adapt_time_nxt;
      drain_time_r <= drain_time_nxt;
      first_r      <= first_nxt;
    end
  end

  // Working registers of the current word
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    now_r      <= now_nxt;
    ect_r      <= ect_nxt;
    u_r        <= u_nxt;
    lim_r      <= lim_nxt;
    tmp_r      <= tmp_nxt;
    dec_r      <= dec_nxt;
    m_this_r   <= m_this_nxt;
    m_head_r   <= m_head_nxt;
    d_this_r   <= d_this_nxt;
    hdrops_r   <= hdrops_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is still in progress");

  a_mark_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.mark_this && out_data.mark_head))
    else $error("both the arriving and the head packet marked");

  a_head_drops_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.head_drops != 2'd3))
    else $error("more than two head drops");

endmodule
